@@ rtl/pidz_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidz_pkg
// Widths, constants and shared types of the PID step block with integral zone.
// ----------------------------------------------------------------------------
package pidz_pkg;

	// field widths
	localparam int ERR_W     = 32;
	localparam int MS_W      = 16;
	localparam int GAIN_W    = 31;
	localparam int CFG_IDX_W = 2;
	localparam int FRAC_W    = 16;

	// elapsed time after substitution, 0..100
	localparam int MSC_W     = 7;
	localparam int DT_MAX_MS = 100;
	localparam int DT_SUB_MS = 20;
	localparam int MS_PER_S  = 1000;

	// Q16.16 limits
	localparam int ZONE_Q      = 30 * 65536;
	localparam int INT_MAX_Q   = 100 * 65536;
	localparam int ITERM_MAX_Q = 80 * 65536;
	localparam int LIMIT_RST   = 100 * 65536;

	// x / 1000 as (x * RECIP_1000) >> RECIP_SH, exact for x < 2^28
	localparam longint RECIP_1000 = 64'd274877907;
	localparam int     RECIP_SH   = 38;
	localparam int     INC_W      = 18;

	// integral accumulator holds +-100.0
	localparam int ACC_W = 24;
	localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(INT_MAX_Q);

	// running sum of the three terms
	localparam int SUM_W = 60;

	// shared multiplier
	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;

	// serial divider for the derivative: |diff| * 1000 < 2^42, divisor <= 100
	localparam int DIV_N_W   = 42;
	localparam int DIV_D_W   = MSC_W;
	localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P       = 2'd0,
		CFG_GAIN_I       = 2'd1,
		CFG_GAIN_D       = 2'd2,
		CFG_OUTPUT_LIMIT = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_i;
		logic [GAIN_W-1:0] gain_d;
		logic [GAIN_W-1:0] output_limit;
	} cfg_t;

	typedef struct packed {
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_N_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ rtl/pidz_sample_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidz_sample_if
// Input channel: one control sample per transfer.
// ----------------------------------------------------------------------------
interface pidz_sample_if import pidz_pkg::*; ();

	logic                    valid;
	logic                    ready;
	logic                    opcode;
	logic signed [ERR_W-1:0] error_in;
	logic [MS_W-1:0]         elapsed_ms;

	modport source (output valid, output opcode, output error_in, output elapsed_ms,
		input ready);
	modport sink (input valid, input opcode, input error_in, input elapsed_ms,
		output ready);

endinterface

@@ rtl/pidz_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidz_result_if
// Output channel: one saturated drive value per transfer.
// ----------------------------------------------------------------------------
interface pidz_result_if import pidz_pkg::*; ();

	logic                    valid;
	logic                    ready;
	logic signed [ERR_W-1:0] drive;

	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);

endinterface

@@ rtl/pid_step_integral_zone_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_step_integral_zone_unit
// PID step with integral zone and anti-windup, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// One control sample gives one drive value. The input is ready again once
// the result of a control sample is registered, so one sample is in flight
// at a time; the pace is set by the restoring divider that forms the
// derivative (one quotient bit per cycle), with the integral, proportional
// and integral-term products run on the shared 32 x 32 multiplier while it
// works. A clear opcode goes from idle straight to the final step, which
// registers its result. A finished result waits in the output register, so
// the next sample is taken while it is still held; a sample that finishes
// while the register is still full waits in its last step until the
// register frees. The user must see that gains and limit are written only
// while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pid_step_integral_zone_unit import pidz_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	pidz_sample_if.sink          sample,
	pidz_result_if.source        result,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data
);

	cfg_t              cfg_q;
	mul_req_t          mul_req;
	logic [PROD_W-1:0] prod;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p       <= '0;
			cfg_q.gain_i       <= '0;
			cfg_q.gain_d       <= '0;
			cfg_q.output_limit <= GAIN_W'(LIMIT_RST);
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_GAIN_P:       cfg_q.gain_p       <= cfg_data;
				CFG_GAIN_I:       cfg_q.gain_i       <= cfg_data;
				CFG_GAIN_D:       cfg_q.gain_d       <= cfg_data;
				CFG_OUTPUT_LIMIT: cfg_q.output_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	pidz_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	pidz_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	pidz_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.sample  (sample),
		.result  (result),
		.mul_req (mul_req),
		.prod    (prod),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

endmodule

@@ rtl/pidz_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidz_mul
// Shared 32 x 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module pidz_mul import pidz_pkg::*; (
	input  logic              clk,
	input  mul_req_t          req,
	output logic [PROD_W-1:0] prod
);

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(req.a) * PROD_W'(req.b);
	end

	assign prod = prod_q;

endmodule

@@ rtl/pidz_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidz_div
// Restoring divider, one quotient bit per cycle, DIV_N_W quotient bits per divide.
// ----------------------------------------------------------------------------
module pidz_div import pidz_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_D_W-1:0]   dvs_q;

	logic [DIV_D_W:0]     trial;
	logic [DIV_D_W:0]     diff;
	logic                 ge;

	always_comb begin
		trial = {rem_q, quo_q[DIV_N_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_N_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top bit is dropped
			rem_q <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

`ifndef ASSERT_OFF
	a_busy_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q))
		else $error("divider busy and done together");

	a_start_loads: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> (busy_q && !done_q && cnt_q == DIV_CNT_W'(DIV_N_W)))
		else $error("divider did not start a full divide");
`endif

endmodule

@@ rtl/pidz_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidz_seq
// Sequencer and datapath: drives the shared multiplier and the divider,
// keeps the integral and last error, and holds the result register.
// ----------------------------------------------------------------------------
module pidz_seq import pidz_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	pidz_sample_if.sink       sample,
	pidz_result_if.source     result,
	output mul_req_t          mul_req,
	input  logic [PROD_W-1:0] prod,
	output div_req_t          div_req,
	input  div_rsp_t          div_rsp
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_DSTART,
		ST_RECIP,
		ST_ACC,
		ST_IMUL,
		ST_PMUL,
		ST_PADD,
		ST_DWAIT,
		ST_DHI,
		ST_DADD,
		ST_SAT
	} state_t;

	state_t                  state_q;
	logic                    res_valid_q;
	logic signed [ERR_W-1:0] res_drive_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ERR_W-1:0] prev_q;

	logic [ERR_W-1:0]        err_mag_q;
	logic                    err_neg_q;
	logic [ERR_W-1:0]        diff_mag_q;
	logic                    diff_neg_q;
	logic [MSC_W-1:0]        ms_q;
	logic                    zone_q;
	logic signed [SUM_W-1:0] sum_q;

	// sample decode
	logic [ERR_W-1:0]        err_u;
	logic [ERR_W-1:0]        err_mag_c;
	logic [ERR_W:0]          diff_c;
	logic [ERR_W:0]          diff_mag_c;
	logic [MSC_W-1:0]        msc_c;
	logic                    take;

	// integral update
	logic [INC_W-1:0]        inc;
	logic signed [ACC_W+1:0] acc_wide;
	logic signed [ACC_W+1:0] inc_wide;
	logic signed [ACC_W+1:0] acc_sum;
	logic signed [ACC_W-1:0] acc_next;
	logic [ACC_W-1:0]        acc_mag;

	// term accumulation
	logic [PROD_W-FRAC_W-1:0] prod_sh;
	logic [SUM_W-2:0]         add_mag;
	logic                     add_neg;
	logic                     add_init;
	logic                     add_en;
	logic [SUM_W-1:0]         add_u;
	logic [SUM_W-1:0]         addend;
	logic signed [SUM_W-1:0]  sum_next;

	// derivative magnitude and output saturation
	logic [DIV_N_W-1:0]       dmag;
	logic signed [SUM_W-1:0]  lim_s;
	logic signed [SUM_W-1:0]  neg_lim;
	logic signed [ERR_W-1:0]  drive_c;

	assign take = sample.valid && (state_q == ST_IDLE);

	always_comb begin
		err_u      = sample.error_in;
		err_mag_c  = err_u[ERR_W-1] ? (~err_u + 1'b1) : err_u;
		diff_c     = {err_u[ERR_W-1], err_u} - {prev_q[ERR_W-1], prev_q};
		diff_mag_c = diff_c[ERR_W] ? (~diff_c + 1'b1) : diff_c;
		if (sample.elapsed_ms > MS_W'(DT_MAX_MS))
			msc_c = MSC_W'(DT_SUB_MS);
		else
			msc_c = sample.elapsed_ms[MSC_W-1:0];
	end

	always_comb begin
		inc      = prod[RECIP_SH +: INC_W];
		acc_wide = (ACC_W+2)'(acc_q);
		inc_wide = (ACC_W+2)'({1'b0, inc});
		acc_sum  = err_neg_q ? (acc_wide - inc_wide) : (acc_wide + inc_wide);
		if (acc_sum > (ACC_W+2)'(ACC_MAX))
			acc_next = ACC_MAX;
		else if (acc_sum < -((ACC_W+2)'(ACC_MAX)))
			acc_next = -ACC_MAX;
		else
			acc_next = acc_sum[ACC_W-1:0];
		acc_mag = acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
	end

	assign dmag = (ms_q == '0) ? '0 : div_rsp.quotient;

	// shared multiplier operands
	always_comb begin
		mul_req = '0;
		case (state_q)
			ST_DIFF: begin
				mul_req.a = diff_mag_q;
				mul_req.b = MUL_W'(MS_PER_S);
			end
			ST_DSTART: begin
				mul_req.a = err_mag_q;
				mul_req.b = MUL_W'(ms_q);
			end
			ST_RECIP: begin
				mul_req.a = prod[MUL_W-1:0];
				mul_req.b = MUL_W'(RECIP_1000);
			end
			ST_IMUL: begin
				mul_req.a = MUL_W'(acc_mag);
				mul_req.b = MUL_W'(cfg.gain_i);
			end
			ST_PMUL: begin
				mul_req.a = err_mag_q;
				mul_req.b = MUL_W'(cfg.gain_p);
			end
			ST_DWAIT: begin
				mul_req.a = dmag[MUL_W-1:0];
				mul_req.b = MUL_W'(cfg.gain_d);
			end
			ST_DHI: begin
				mul_req.a = MUL_W'(dmag[DIV_N_W-1:MUL_W]);
				mul_req.b = MUL_W'(cfg.gain_d);
			end
			default: mul_req = '0;
		endcase
	end

	always_comb begin
		div_req.start    = (state_q == ST_DSTART);
		div_req.dividend = prod[DIV_N_W-1:0];
		div_req.divisor  = ms_q;
	end

	// term selection for the running sum
	always_comb begin
		prod_sh  = prod[PROD_W-1:FRAC_W];
		add_mag  = '0;
		add_neg  = 1'b0;
		add_init = 1'b0;
		add_en   = 1'b0;
		case (state_q)
			ST_PMUL: begin
				// integral term, clamped to 80.0
				add_en   = 1'b1;
				add_init = 1'b1;
				add_neg  = acc_q[ACC_W-1];
				if (prod_sh > (PROD_W-FRAC_W)'(ITERM_MAX_Q))
					add_mag = (SUM_W-1)'(ITERM_MAX_Q);
				else
					add_mag = (SUM_W-1)'(prod_sh);
			end
			ST_PADD: begin
				add_en  = 1'b1;
				add_neg = err_neg_q;
				add_mag = (SUM_W-1)'(prod_sh);
			end
			ST_DHI: begin
				add_en  = 1'b1;
				add_neg = diff_neg_q;
				add_mag = (SUM_W-1)'(prod_sh);
			end
			ST_DADD: begin
				// high derivative word: exact, shifted up by 32 - 16
				add_en  = 1'b1;
				add_neg = diff_neg_q;
				add_mag = {prod[SUM_W-2-FRAC_W:0], {FRAC_W{1'b0}}};
			end
			default: add_en = 1'b0;
		endcase
		add_u    = {1'b0, add_mag};
		addend   = add_neg ? (~add_u + 1'b1) : add_u;
		sum_next = (add_init ? '0 : sum_q) + addend;
	end

	always_comb begin
		lim_s   = SUM_W'(cfg.output_limit);
		neg_lim = -lim_s;
		if (sum_q > lim_s)
			drive_c = lim_s[ERR_W-1:0];
		else if (sum_q < neg_lim)
			drive_c = neg_lim[ERR_W-1:0];
		else
			drive_c = sum_q[ERR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			res_drive_q <= '0;
			acc_q       <= '0;
			prev_q      <= '0;
		end else begin
			// the final step sets the result register itself
			if (result.ready && (state_q != ST_SAT))
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						if (sample.opcode) begin
							acc_q   <= '0;
							prev_q  <= '0;
							state_q <= ST_SAT;
						end else begin
							prev_q  <= sample.error_in;
							state_q <= ST_DIFF;
						end
					end
				end
				ST_DIFF:   state_q <= ST_DSTART;
				ST_DSTART: state_q <= ST_RECIP;
				ST_RECIP:  state_q <= ST_ACC;
				ST_ACC: begin
					acc_q   <= zone_q ? acc_next : '0;
					state_q <= ST_IMUL;
				end
				ST_IMUL:   state_q <= ST_PMUL;
				ST_PMUL:   state_q <= ST_PADD;
				ST_PADD:   state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_rsp.done)
						state_q <= ST_DHI;
				end
				ST_DHI:    state_q <= ST_DADD;
				ST_DADD:   state_q <= ST_SAT;
				ST_SAT: begin
					if (!res_valid_q || result.ready) begin
						res_valid_q <= 1'b1;
						res_drive_q <= drive_c;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			err_mag_q  <= err_mag_c;
			err_neg_q  <= err_u[ERR_W-1];
			diff_mag_q <= diff_mag_c[ERR_W-1:0];
			diff_neg_q <= diff_c[ERR_W];
			ms_q       <= msc_c;
			zone_q     <= err_mag_c < ERR_W'(ZONE_Q);
			sum_q      <= '0;
		end else if (add_en) begin
			sum_q <= sum_next;
		end
	end

	assign sample.ready = (state_q == ST_IDLE);
	assign result.valid = res_valid_q;
	assign result.drive = res_drive_q;

`ifndef ASSERT_OFF
	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q <= ACC_MAX) && (acc_q >= -ACC_MAX))
		else $error("integral outside +-100");

	a_clear_op: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready && sample.opcode)
		|=> (acc_q == '0 && prev_q == '0 && state_q == ST_SAT))
		else $error("clear opcode did not clear state");

	a_div_before_dterm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DHI) |-> $past(div_rsp.done))
		else $error("derivative used before divide finished");
`endif

endmodule

@@ tb/pid_step_integral_zone_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_step_integral_zone_unit_tb
// Drives control samples and clear opcodes through the PID step block under
// several gain and limit settings and checks every drive value against a
// cycle-free model of the Q16.16 arithmetic, with random idling on both sides.
// ----------------------------------------------------------------------------
module pid_step_integral_zone_unit_tb import pidz_pkg::*; ();

	class drive_scoreboard;
		bit [GAIN_W-1:0]         gain_p;
		bit [GAIN_W-1:0]         gain_i;
		bit [GAIN_W-1:0]         gain_d;
		bit [GAIN_W-1:0]         out_limit;
		longint                  integ;
		longint                  last_err;
		logic signed [ERR_W-1:0] pending_drive[$];
		int unsigned             fail_count;

		function new();
			gain_p     = '0;
			gain_i     = '0;
			gain_d     = '0;
			out_limit  = GAIN_W'(LIMIT_RST);
			integ      = 0;
			last_err   = 0;
			fail_count = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, bit [GAIN_W-1:0] val);
			case (idx)
				CFG_GAIN_P:       gain_p = val;
				CFG_GAIN_I:       gain_i = val;
				CFG_GAIN_D:       gain_d = val;
				CFG_OUTPUT_LIMIT: out_limit = val;
				default: ;
			endcase
		endfunction

		// value * gain / 2^16 with the magnitude truncated
		function longint scale_gain(longint v, bit [GAIN_W-1:0] g);
			bit        neg;
			bit [63:0] mag;
			bit [63:0] prod;
			neg  = v < 0;
			mag  = neg ? -v : v;
			prod = (mag >> 16) * 64'(g) + (((mag & 64'hFFFF) * 64'(g)) >> 16);
			return neg ? -longint'(prod) : longint'(prod);
		endfunction

		function void take_sample(bit op, logic signed [ERR_W-1:0] err, logic [MS_W-1:0] ms);
			longint      e;
			longint      deriv;
			longint      iterm;
			longint      pwr;
			longint      lim;
			int unsigned dt;
			e = longint'(err);
			if (op) begin
				integ    = 0;
				last_err = 0;
				pending_drive.push_back('0);
				return;
			end
			dt = 32'(ms);
			if (dt > DT_MAX_MS)
				dt = DT_SUB_MS;
			if ((e < 0 ? -e : e) < ZONE_Q) begin
				integ += (e * longint'(dt)) / longint'(MS_PER_S);
				if (integ > INT_MAX_Q)
					integ = INT_MAX_Q;
				if (integ < -INT_MAX_Q)
					integ = -INT_MAX_Q;
			end else begin
				integ = 0;
			end
			deriv    = (dt != 0) ? ((e - last_err) * MS_PER_S) / longint'(dt) : 0;
			last_err = e;
			iterm = scale_gain(integ, gain_i);
			if (iterm > ITERM_MAX_Q)
				iterm = ITERM_MAX_Q;
			else if (iterm < -ITERM_MAX_Q)
				iterm = -ITERM_MAX_Q;
			pwr = scale_gain(e, gain_p) + iterm + scale_gain(deriv, gain_d);
			lim = longint'(out_limit);
			if (pwr > lim)
				pwr = lim;
			if (pwr < -lim)
				pwr = -lim;
			pending_drive.push_back(32'(pwr));
		endfunction

		function void check_drive(logic signed [ERR_W-1:0] got);
			logic signed [ERR_W-1:0] want;
			if (pending_drive.size() == 0) begin
				$display("%0t: drive %0d with nothing expected", $time, got);
				fail_count++;
				return;
			end
			want = pending_drive.pop_front();
			if (got !== want) begin
				$display("%0t: drive mismatch, expected %0d, actual %0d", $time, want, got);
				fail_count++;
			end
		endfunction

		function int unsigned outstanding();
			return pending_drive.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [GAIN_W-1:0]    cfg_data;

	pidz_sample_if sample_ch ();
	pidz_result_if result_ch ();

	drive_scoreboard sb;
	bit              tx_idle = 1'b1;
	bit              rx_idle = 1'b1;
	int unsigned     rx_hold = 0;

	pid_step_integral_zone_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#8ms;
		$display("Verification failed");
		$finish;
	end

	function automatic bit [GAIN_W-1:0] pick_gain(int unsigned modest);
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return GAIN_W'($urandom);
			default: return GAIN_W'($urandom_range(0, modest));
		endcase
	endfunction

	function automatic bit [GAIN_W-1:0] pick_limit();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return GAIN_W'($urandom);
			default: return GAIN_W'($urandom_range(65536, 200 * 65536));
		endcase
	endfunction

	task automatic write_cfg(bit [GAIN_W-1:0] gp, bit [GAIN_W-1:0] gi,
		bit [GAIN_W-1:0] gd, bit [GAIN_W-1:0] lim);
		bit [GAIN_W-1:0] vals[4];
		cfg_idx_t        idx;
		vals[CFG_GAIN_P]       = gp;
		vals[CFG_GAIN_I]       = gi;
		vals[CFG_GAIN_D]       = gd;
		vals[CFG_OUTPUT_LIMIT] = lim;
		idx = CFG_GAIN_P;
		repeat (4) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= vals[idx];
			@(posedge clk);
			sb.set_reg(idx, vals[idx]);
			idx = idx.next();
		end
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_sample(bit op, logic signed [ERR_W-1:0] err, logic [MS_W-1:0] ms);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid      <= 1'b1;
		sample_ch.opcode     <= op;
		sample_ch.error_in   <= err;
		sample_ch.elapsed_ms <= ms;
		// ready as seen at the edge itself
		@(posedge clk iff (sample_ch.ready === 1'b1));
		sb.take_sample(op, err, ms);
	endtask

	// sender pauses until every outstanding drive value has come back
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	// runs of well-formed in-zone samples so the integral winds up to its
	// clamp, mixed with runs carrying noise, zone edges and clears
	task automatic send_random(int unsigned count);
		int unsigned             run_left;
		bit                      run_neg;
		bit                      clean;
		int unsigned             pick;
		int unsigned             mag;
		int unsigned             wsel;
		bit                      op;
		logic signed [ERR_W-1:0] err;
		logic [MS_W-1:0]         ms;
		run_left = 0;
		repeat (count) begin
			if (run_left == 0) begin
				run_left = $urandom_range(40, 150);
				run_neg  = 1'($urandom_range(0, 1));
				clean    = $urandom_range(0, 9) < 7;
			end
			run_left--;
			pick = clean ? 99 : $urandom_range(0, 99);
			op   = 1'b0;
			if (pick < 5) begin
				op  = 1'b1;
				err = $urandom;
				ms  = MS_W'($urandom);
			end else if (pick < 35) begin
				err = $urandom;
				ms  = MS_W'($urandom);
			end else begin
				if (pick < 50)
					mag = $urandom_range(ZONE_Q - 2, ZONE_Q + 1);
				else if ($urandom_range(0, 3) == 0)
					mag = $urandom_range(0, ZONE_Q - 1);
				else
					mag = $urandom_range(15 * 65536, ZONE_Q - 1);
				err  = (run_neg ^ ($urandom_range(0, 9) == 0)) ? -mag : mag;
				wsel = $urandom_range(0, 19);
				if (wsel == 0)
					ms = '0;
				else if (wsel == 1)
					ms = MS_W'(DT_MAX_MS);
				else if (wsel == 2)
					ms = MS_W'($urandom_range(DT_MAX_MS + 1, 65535));
				else
					ms = MS_W'($urandom_range(DT_SUB_MS, DT_MAX_MS));
			end
			send_sample(op, err, ms);
		end
	endtask

	initial begin : result_sink
		int unsigned stall;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold != 0) begin
				stall   = rx_hold;
				rx_hold = 0;
			end else begin
				stall = rx_idle ? $urandom_range(0, 8) : 0;
			end
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			// valid and drive as seen at the edge itself
			@(posedge clk iff (result_ch.valid === 1'b1));
			sb.check_drive(result_ch.drive);
		end
	end

	initial begin : stimulus
		sb = new();
		sample_ch.valid      <= 1'b0;
		sample_ch.opcode     <= 1'b0;
		sample_ch.error_in   <= '0;
		sample_ch.elapsed_ms <= '0;
		result_ch.ready      <= 1'b0;
		cfg_wr_en            <= 1'b0;
		cfg_index            <= CFG_GAIN_P;
		cfg_data             <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: zero gains give zero drive
		send_sample(1'b0, 32'sh0010_0000, 16'd20);
		send_sample(1'b0, -32'sh0003_0000, 16'd0);
		drain();

		// unit-ish gains, limit 100.0
		write_cfg(31'd65536, 31'd131072, 31'd655, GAIN_W'(LIMIT_RST));
		send_sample(1'b0, '0, '0);
		send_sample(1'b0, 32'sh0001_0000, 16'd0);
		send_sample(1'b0, ERR_W'(ZONE_Q - 1), MS_W'(DT_MAX_MS));
		send_sample(1'b0, ERR_W'(ZONE_Q), 16'd50);
		send_sample(1'b0, ERR_W'(-(ZONE_Q - 1)), MS_W'(DT_MAX_MS + 1));
		send_sample(1'b0, ERR_W'(-ZONE_Q), 16'hFFFF);
		send_sample(1'b1, 32'sh7FFF_FFFF, 16'hFFFF);
		send_sample(1'b0, 32'sh7FFF_FFFF, 16'd1);
		send_sample(1'b0, 32'sh8000_0000, MS_W'(DT_MAX_MS));
		send_sample(1'b1, '0, '0);
		repeat (4) send_sample(1'b0, ERR_W'(ZONE_Q - 7), MS_W'(DT_MAX_MS));
		send_sample(1'b0, -32'sd1, 16'd7);
		drain();

		// every gain and the limit at full scale: integral term clamps
		write_cfg('1, '1, '1, '1);
		repeat (2) send_sample(1'b0, ERR_W'(ZONE_Q - 1), MS_W'(DT_MAX_MS));
		repeat (2) send_sample(1'b0, ERR_W'(-(ZONE_Q - 1)), MS_W'(DT_MAX_MS));
		send_sample(1'b0, 32'sh7FFF_FFFF, MS_W'(DT_MAX_MS));
		send_sample(1'b0, 32'sh8000_0000, 16'd1);
		drain();

		// zero limit
		write_cfg(31'd65536, 31'd65536, 31'd65536, '0);
		send_sample(1'b0, 32'sd12345678, 16'd33);
		send_sample(1'b0, -32'sd5, 16'd3);
		drain();

		for (int ph = 0; ph < 16; ph++) begin
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			write_cfg(pick_gain(4 * 65536), pick_gain(4 * 65536), pick_gain(3277),
				pick_limit());
			// long receiver hold-off so the output register fills and input stalls
			if (ph == 2)
				rx_hold = 300;
			send_random(102);
			drain();
		end

		repeat (60) @(posedge clk);
		if (sb.fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
